// ===== hw/rtl/hash_insert_or_find_linear_probe_defines.svh =====
// ============================================================================
// Assertion macros for the linear-probe hash table
// Shared property forms with an active-low reset that disables them.
// ============================================================================
`ifndef HASH_INSERT_OR_FIND_LINEAR_PROBE_DEFINES_SVH
`define HASH_INSERT_OR_FIND_LINEAR_PROBE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HIOLP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HIOLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hiolp_pkg.sv =====
// ============================================================================
// hiolp_pkg
// Types and constants shared by the linear-probe hash table modules.
// ============================================================================
`timescale 1ns / 1ps

package hiolp_pkg;

    localparam int KEY_W        = 64;
    localparam int NUM_W        = 64;
    localparam int CAPACITY_DEF = 1024;

    // Key bits folded into the remainder per cycle of the modulo unit.
    localparam int MOD_STEP   = 4;
    localparam int MOD_CYCLES = KEY_W / MOD_STEP;
    localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [NUM_W-1:0] number_in;
    } t_req;

    typedef struct packed {
        logic                    found;
        logic signed [NUM_W-1:0] number_out;
        logic                    full_res;
    } t_res;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [NUM_W-1:0] number;
    } t_slot;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK
    } t_state;

endpackage

// ===== hw/rtl/hash_insert_or_find_linear_probe.sv =====
// Flow: an accepted request runs the modulo unit to find its home slot, then a read
// state and a check state for each slot probed, until an empty slot or a matching key.
// Busy stays high until the result shows; no new request is taken before then.
// Each probe goes through the single read port of the slot memories.
// Reset: synchronous, active low; afterwards a clearing pass over every slot
// empties the occupied marks with busy high. The receiver cannot stall results.
// ============================================================================
// hash_insert_or_find_linear_probe
// Insert-or-find table with open addressing and linear probing.
// ============================================================================
`timescale 1ns / 1ps

module hash_insert_or_find_linear_probe #(
    parameter int CAPACITY = hiolp_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  hiolp_pkg::t_req   i_req,
    output logic              busy,
    output logic              o_res_valid,
    output hiolp_pkg::t_res   o_res
);

    import hiolp_pkg::*;

    // Slot address width, entry count width and the load limit. A new key is
    // refused once count * 2 >= CAPACITY, i.e. once count reaches ceil(CAPACITY/2).
    localparam int AW   = $clog2(CAPACITY);
    localparam int HALF = (CAPACITY + 1) / 2;
    localparam int CW   = $clog2(HALF + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] LIMIT     = CW'(HALF);
    localparam int SLOT_W = $bits(t_slot);

    t_state           r_state, n_state;
    t_req             r_req,   n_req;
    logic [AW-1:0]    r_pos,   n_pos;
    logic [AW-1:0]    r_clr,   n_clr;
    logic [CW-1:0]    r_count, n_count;
    logic             r_res_valid, n_res_valid;
    t_res             r_res,   n_res;

    logic             w_accept;
    logic             w_mod_done;
    logic [AW-1:0]    w_mod_rem;
    logic             w_used_rd;
    t_slot            w_slot_rd;
    logic             w_hit;
    logic             w_full;

    logic             w_used_we;
    logic [AW-1:0]    w_used_waddr;
    logic             w_used_wdata;
    logic             w_slot_we;
    t_slot            w_slot_wdata;

    assign w_accept = start && !busy;

    // The modulo unit turns the key into its home slot.
    hiolp_mod #(
        .CAPACITY (CAPACITY)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_key   (i_req.key),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    // Occupied marks: cleared by a sweep after reset, set on insert.
    hiolp_ram #(
        .WIDTH (1),
        .DEPTH (CAPACITY)
    ) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (w_used_we),
        .i_waddr (w_used_waddr),
        .i_wdata (w_used_wdata),
        .i_raddr (r_pos),
        .o_rdata (w_used_rd)
    );

    // Key and number of each slot; the read data only counts where the occupied mark is set.
    hiolp_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (r_pos),
        .i_wdata (w_slot_wdata),
        .i_raddr (r_pos),
        .o_rdata (w_slot_rd)
    );

    // In the check state the read data belongs to slot r_pos.
    assign w_hit  = w_used_rd && (w_slot_rd.key == r_req.key);
    assign w_full = (r_count >= LIMIT);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                // An empty slot or a matching key ends the probe.
                if (!w_used_rd || w_hit) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_req        = r_req;
        n_pos        = r_pos;
        n_clr        = r_clr;
        n_count      = r_count;
        n_res_valid  = 1'b0;
        n_res        = r_res;
        w_used_we    = 1'b0;
        w_used_waddr = r_pos;
        w_used_wdata = 1'b0;
        w_slot_we    = 1'b0;
        w_slot_wdata.key    = r_req.key;
        w_slot_wdata.number = r_req.number_in;
        unique case (r_state)
            S_CLEAR: begin
                w_used_we    = 1'b1;
                w_used_waddr = r_clr;
                n_clr        = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_pos = w_mod_rem;
                end
            end
            S_READ: begin
            end
            S_CHECK: begin
                if (w_hit) begin
                    n_res_valid      = 1'b1;
                    n_res.found      = 1'b1;
                    n_res.number_out = w_slot_rd.number;
                    n_res.full_res   = 1'b0;
                end else if (!w_used_rd) begin
                    n_res_valid = 1'b1;
                    if (w_full) begin
                        // New key at the load limit: refused, nothing stored.
                        n_res.found      = 1'b0;
                        n_res.number_out = '0;
                        n_res.full_res   = 1'b1;
                    end else begin
                        w_used_we        = 1'b1;
                        w_used_wdata     = 1'b1;
                        w_slot_we        = 1'b1;
                        n_count          = r_count + 1'b1;
                        n_res.found      = 1'b0;
                        n_res.number_out = r_req.number_in;
                        n_res.full_res   = 1'b0;
                    end
                end else begin
                    // Occupied by another key: step on, wrapping at the end.
                    n_pos = (r_pos == LAST_SLOT) ? '0 : r_pos + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
        r_req <= n_req;
        r_pos <= n_pos;
        r_res <= n_res;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== hw/rtl/hiolp_ram.sv =====
// ============================================================================
// hiolp_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`timescale 1ns / 1ps

module hiolp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/hiolp_mod.sv =====
// ============================================================================
// hiolp_mod
// Iterative key modulo capacity, MOD_STEP key bits per cycle.
// ============================================================================
`timescale 1ns / 1ps

module hiolp_mod #(
    parameter int CAPACITY = hiolp_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hiolp_pkg::KEY_W-1:0]   i_key,
    output logic                          o_done,
    output logic [$clog2(CAPACITY)-1:0]   o_rem
);

    import hiolp_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int RW = AW + 3;
    localparam int IW = $clog2(KEY_W);

    // Weight of each key bit modulo capacity, bit 0 first.
    function automatic logic [KEY_W-1:0][AW-1:0] weight_table();
        logic [KEY_W-1:0][AW-1:0] tab;
        longint unsigned          w;
        w = 64'd1;
        for (int b = 0; b < KEY_W; b++) begin
            tab[b] = AW'(w);
            w      = (w * 64'd2) % 64'(CAPACITY);
        end
        return tab;
    endfunction

    localparam logic [KEY_W-1:0][AW-1:0] WEIGHTS = weight_table();
    localparam logic [RW-1:0] CAP_1 = RW'(CAPACITY);
    localparam logic [RW-1:0] CAP_2 = RW'(2 * CAPACITY);
    localparam logic [RW-1:0] CAP_4 = RW'(4 * CAPACITY);

    logic [KEY_W-1:0]     r_shift, n_shift;
    logic [AW-1:0]        r_rem,   n_rem;
    logic [MOD_CNT_W-1:0] r_cnt,   n_cnt;
    logic                 r_busy,  n_busy;
    logic                 r_done,  n_done;
    logic [IW-1:0]        w_base;
    logic [RW-1:0]        w_sum;

    // The low key bits of this cycle add their weights to the running
    // remainder. The sum stays below five times capacity, so three compare
    // and subtract steps bring it back under capacity.
    always_comb begin
        w_base = IW'(r_cnt) * IW'(MOD_STEP);
        w_sum  = RW'(r_rem);
        for (int j = 0; j < MOD_STEP; j++) begin
            if (r_shift[j]) begin
                w_sum = w_sum + RW'(WEIGHTS[w_base + IW'(j)]);
            end
        end
        if (w_sum >= CAP_4) begin
            w_sum = w_sum - CAP_4;
        end
        if (w_sum >= CAP_2) begin
            w_sum = w_sum - CAP_2;
        end
        if (w_sum >= CAP_1) begin
            w_sum = w_sum - CAP_1;
        end
    end

    always_comb begin
        n_shift = r_shift;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_shift = i_key;
            n_rem   = '0;
            n_cnt   = '0;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_shift = r_shift >> MOD_STEP;
            n_rem   = w_sum[AW-1:0];
            n_cnt   = r_cnt + 1'b1;
            if (r_cnt == MOD_CNT_W'(MOD_CYCLES - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_shift <= n_shift;
        r_rem   <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/hiolp_chk.sv =====
// ============================================================================
// hiolp_chk
// Port-level checks on the hash table, attached to the top level by bind.
// ============================================================================
`timescale 1ns / 1ps
`include "hash_insert_or_find_linear_probe_defines.svh"

module hiolp_chk (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic            o_res_valid,
    input  hiolp_pkg::t_res o_res
);

    import hiolp_pkg::*;

    // Every request passes the modulo unit and a probe, so a result never repeats back to back.
    `HIOLP_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_res_valid, !o_res_valid, "result strobe held for more than one cycle")

    // A request that was just accepted cannot have finished yet.
    `HIOLP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, start && !busy, busy && !o_res_valid, "block not busy right after a transfer")

    // A key is either found or refused as new, never both.
    `HIOLP_ASSERT_SAME(a_found_xor_full, i_clk, i_rst_n, o_res_valid, !(o_res.found && o_res.full_res), "found and full reported together")

    // A refused request stores nothing and reports number zero.
    `HIOLP_ASSERT_SAME(a_full_zero, i_clk, i_rst_n, o_res_valid && o_res.full_res, o_res.number_out == '0, "refused request with nonzero number")

endmodule

bind hash_insert_or_find_linear_probe hiolp_chk u_hiolp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);
